// File: sv/text_console_writer_assert.svh
// ---------------------------------------------------------------------------
// text_console_writer_assert.svh
// Assertion macros for the text console writer. Define NO_ASSERTIONS to
// compile them out.
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// consequent must hold in the same cycle as the antecedent
`define TCW_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("text_console_writer: assertion failed");

// consequent must hold in the cycle after the antecedent
`define TCW_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("text_console_writer: assertion failed");

`else

`define TCW_ASSERT_NOW(lbl, ante, cons)
`define TCW_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: sv/tcw_pkg.sv
// ---------------------------------------------------------------------------
// tcw_pkg
// Shared field widths, request and character codes, and the command and
// status bundles between controller and datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcw_pkg;

	localparam int REQ_W     = 2;
	localparam int CHAR_W    = 8;
	localparam int IDX_W     = 11;
	localparam int COL_OUT_W = 7;
	localparam int ROW_OUT_W = 5;
	localparam int LOC_W     = 11;
	localparam int CELL_W    = 16;
	localparam int COLOR_W   = 4;
	localparam int CFG_IDX_W = 1;

	localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
	localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_FG = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BG = 1'b1;

	localparam logic [COLOR_W-1:0] FG_RESET = 4'hF;
	localparam logic [COLOR_W-1:0] BG_RESET = 4'h0;

	localparam logic [CHAR_W-1:0] CH_BS       = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB      = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF       = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'h20;
	localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'h7F;

	localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

	typedef struct packed {
		logic accept;    // capture request fields
		logic put;       // apply a put step to the cursor (and write the cell for a printable character)
		logic cnt_clr;   // walk counter to zero
		logic cnt_inc;   // advance walk counter
		logic copy_rd;   // scroll: read cell one row below the counter
		logic blank_we;  // write blank at the counter
		logic cell_rd;   // read the requested cell
		logic emit;      // load result registers and strobe done
	} tcw_cmd_t;

	typedef struct packed {
		logic need_scroll;
		logic copy_last;
		logic cnt_last;
	} tcw_stat_t;

endpackage

// File: sv/text_console_writer.sv
// ---------------------------------------------------------------------------
// text_console_writer
// Text-mode console, COLUMNS x ROWS cells of attribute and character.
// Put and read requests end with a done strobe, as does the unused request
// type; a put that scrolls copies each row up and then blanks the bottom row,
// and clear blanks every cell (one cell per cycle). One transaction at a
// time; start is taken only while busy is low, done cannot be stalled.
// After reset busy stays high while the screen is blanked; configuration
// writes are taken at any time.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "text_console_writer_assert.svh"

module text_console_writer #(
	parameter int COLUMNS  = 80,
	parameter int ROWS     = 25,
	parameter int TAB_STOP = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [tcw_pkg::REQ_W-1:0]     req_type,
	input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
	input  logic [tcw_pkg::IDX_W-1:0]     cell_index,
	input  logic                          cfg_wr_en,
	input  logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tcw_pkg::COLOR_W-1:0]   cfg_data,
	output logic                          done,
	output logic [tcw_pkg::COL_OUT_W-1:0] cursor_col,
	output logic [tcw_pkg::ROW_OUT_W-1:0] cursor_row,
	output logic [tcw_pkg::LOC_W-1:0]     cursor_location,
	output logic [tcw_pkg::CELL_W-1:0]    read_data
);

	import tcw_pkg::*;

	tcw_cmd_t  cmd;
	tcw_stat_t stat;

	tcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.busy     (busy),
		.cmd      (cmd),
		.stat     (stat)
	);

	tcw_datapath #(
		.COLUMNS  (COLUMNS),
		.ROWS     (ROWS),
		.TAB_STOP (TAB_STOP)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.req_type        (req_type),
		.char_code       (char_code),
		.cell_index      (cell_index),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.done            (done),
		.cursor_col      (cursor_col),
		.cursor_row      (cursor_row),
		.cursor_location (cursor_location),
		.read_data       (read_data)
	);

	`TCW_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy)
	`TCW_ASSERT_NEXT(a_done_single_cycle, done, !done)
	`TCW_ASSERT_NOW(a_done_when_idle, done, !busy)
	`TCW_ASSERT_NOW(a_done_cursor_on_screen, done, (32'(cursor_col) < 32'(COLUMNS)) && (32'(cursor_row) < 32'(ROWS)))

endmodule

// File: sv/tcw_ram.sv
// ---------------------------------------------------------------------------
// tcw_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: sv/tcw_datapath.sv
// ---------------------------------------------------------------------------
// tcw_datapath
// Cursor registers, walk counter, screen RAM, color registers and result
// registers of the text console writer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcw_datapath #(
	parameter int COLUMNS  = 80,
	parameter int ROWS     = 25,
	parameter int TAB_STOP = 4
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  tcw_pkg::tcw_cmd_t                  cmd,
	output tcw_pkg::tcw_stat_t                 stat,
	input  logic [tcw_pkg::REQ_W-1:0]          req_type,
	input  logic [tcw_pkg::CHAR_W-1:0]         char_code,
	input  logic [tcw_pkg::IDX_W-1:0]          cell_index,
	input  logic                               cfg_wr_en,
	input  logic [tcw_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tcw_pkg::COLOR_W-1:0]        cfg_data,
	output logic                               done,
	output logic [tcw_pkg::COL_OUT_W-1:0]      cursor_col,
	output logic [tcw_pkg::ROW_OUT_W-1:0]      cursor_row,
	output logic [tcw_pkg::LOC_W-1:0]          cursor_location,
	output logic [tcw_pkg::CELL_W-1:0]         read_data
);

	import tcw_pkg::*;

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int COLW  = $clog2(COLUMNS);
	localparam int CW    = $clog2(COLUMNS + TAB_STOP + 1);
	localparam int RW    = $clog2(ROWS);
	localparam int MW    = $clog2(TAB_STOP);

	logic [COLW-1:0]    col_q;
	logic [MW-1:0]      mod_q;   // col_q modulo TAB_STOP, tracked incrementally
	logic [RW-1:0]      row_q;
	logic [AW-1:0]      base_q;  // row_q * COLUMNS
	logic [AW-1:0]      cnt_q;
	logic               copy_vld_s1;
	logic [AW-1:0]      copy_addr_s1;
	logic [REQ_W-1:0]   req_q;
	logic [CHAR_W-1:0]  char_q;
	logic [IDX_W-1:0]   idx_q;
	logic [COLOR_W-1:0] fg_q;
	logic [COLOR_W-1:0] bg_q;
	logic               done_q;
	logic [COL_OUT_W-1:0] out_col_q;
	logic [ROW_OUT_W-1:0] out_row_q;
	logic [LOC_W-1:0]     out_loc_q;
	logic [CELL_W-1:0]    out_rd_q;

	logic [CW-1:0]     col_sum;
	logic [MW-1:0]     mod_sum;
	logic              row_inc;
	logic              print_ch;
	logic              last_row;
	logic              in_range;
	logic [AW-1:0]     loc;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [CELL_W-1:0] ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [CELL_W-1:0] ram_rdata;

	// next cursor for a put transaction
	always_comb begin
		col_sum  = CW'(col_q);
		mod_sum  = mod_q;
		row_inc  = 1'b0;
		print_ch = (char_q >= CH_PRINT_LO) && (char_q <= CH_PRINT_HI);
		unique case (char_q)
			CH_BS: begin
				if (col_q != '0) begin
					col_sum = CW'(col_q) - CW'(1);
					mod_sum = (mod_q == '0) ? MW'(TAB_STOP - 1) : mod_q - MW'(1);
				end
			end
			CH_TAB: begin
				col_sum = CW'(col_q) + CW'(TAB_STOP) - CW'(mod_q);
				mod_sum = '0;
			end
			CH_CR: begin
				col_sum = '0;
				mod_sum = '0;
			end
			CH_LF: begin
				col_sum = '0;
				mod_sum = '0;
				row_inc = 1'b1;
			end
			default: begin
				if (print_ch) begin
					col_sum = CW'(col_q) + CW'(1);
					mod_sum = (mod_q == MW'(TAB_STOP - 1)) ? '0 : mod_q + MW'(1);
				end
			end
		endcase
		if (col_sum >= CW'(COLUMNS)) begin
			col_sum = '0;
			mod_sum = '0;
			row_inc = 1'b1;
		end
	end

	assign last_row = (row_q == RW'(ROWS - 1));
	assign in_range = (32'(idx_q) < 32'(CELLS));
	assign loc      = base_q + AW'(col_q);

	assign stat.need_scroll = row_inc && last_row;
	assign stat.copy_last   = (cnt_q == AW'(CELLS - COLUMNS - 1));
	assign stat.cnt_last    = (cnt_q == AW'(CELLS - 1));

	// write port: character, then scroll copy (in the cycle after its read), then blank
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q;
		ram_wdata = BLANK_CELL;
		priority if (cmd.put && print_ch) begin
			ram_we    = 1'b1;
			ram_waddr = loc;
			ram_wdata = {bg_q, fg_q, char_q};
		end else if (copy_vld_s1) begin
			ram_we    = 1'b1;
			ram_waddr = copy_addr_s1;
			ram_wdata = ram_rdata;
		end else if (cmd.blank_we) begin
			ram_we    = 1'b1;
		end
	end

	assign ram_raddr = cmd.cell_rd ? AW'(idx_q) : cnt_q + AW'(COLUMNS);

	tcw_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELLS)
	) u_screen (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			mod_q       <= '0;
			row_q       <= '0;
			base_q      <= '0;
			cnt_q       <= '0;
			copy_vld_s1 <= 1'b0;
			fg_q        <= FG_RESET;
			bg_q        <= BG_RESET;
			done_q      <= 1'b0;
		end else begin
			if (cmd.put) begin
				col_q <= COLW'(col_sum);
				mod_q <= mod_sum;
				if (row_inc && !last_row) begin
					row_q  <= row_q + RW'(1);
					base_q <= base_q + AW'(COLUMNS);
				end
			end
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + AW'(1);
			end
			copy_vld_s1 <= cmd.copy_rd;
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_FG: fg_q <= cfg_data;
					REG_BG: bg_q <= cfg_data;
				endcase
			end
			done_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		copy_addr_s1 <= cnt_q;
		if (cmd.accept) begin
			req_q  <= req_type;
			char_q <= char_code;
			idx_q  <= cell_index;
		end
		if (cmd.emit) begin
			out_col_q <= COL_OUT_W'(col_q);
			out_row_q <= ROW_OUT_W'(row_q);
			out_loc_q <= LOC_W'(loc);
			out_rd_q  <= (req_q == REQ_READ && in_range) ? ram_rdata : '0;
		end
	end

	assign done            = done_q;
	assign cursor_col      = out_col_q;
	assign cursor_row      = out_row_q;
	assign cursor_location = out_loc_q;
	assign read_data       = out_rd_q;

endmodule

// File: sv/tcw_ctrl.sv
// ---------------------------------------------------------------------------
// tcw_ctrl
// Sequencer of the text console writer: reset clearing pass, put, scroll,
// clear and read transactions.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcw_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [tcw_pkg::REQ_W-1:0] req_type,
	output logic                      busy,
	output tcw_pkg::tcw_cmd_t         cmd,
	input  tcw_pkg::tcw_stat_t        stat
);

	import tcw_pkg::*;

	typedef enum logic [7:0] {
		ST_INIT   = 8'b0000_0001,
		ST_IDLE   = 8'b0000_0010,
		ST_PUT    = 8'b0000_0100,
		ST_SCROLL = 8'b0000_1000,
		ST_DRAIN  = 8'b0001_0000,
		ST_BLANK  = 8'b0010_0000,
		ST_READ   = 8'b0100_0000,
		ST_DONE   = 8'b1000_0000
	} tcw_state_t;

	tcw_state_t state_q;
	tcw_state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_INIT: begin
				cmd.blank_we = 1'b1;
				cmd.cnt_inc  = 1'b1;
				if (stat.cnt_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					unique case (req_type)
						REQ_PUT:   state_d = ST_PUT;
						REQ_CLEAR: begin
							cmd.cnt_clr = 1'b1;
							state_d     = ST_BLANK;
						end
						REQ_READ:  state_d = ST_READ;
						default:   state_d = ST_DONE;
					endcase
				end
			end
			ST_PUT: begin
				cmd.put     = 1'b1;
				cmd.cnt_clr = 1'b1;
				state_d     = stat.need_scroll ? ST_SCROLL : ST_DONE;
			end
			ST_SCROLL: begin
				cmd.copy_rd = 1'b1;
				cmd.cnt_inc = 1'b1;
				if (stat.copy_last) begin
					state_d = ST_DRAIN;
				end
			end
			// last copy write lands here; counter now points at the bottom row
			ST_DRAIN: state_d = ST_BLANK;
			ST_BLANK: begin
				cmd.blank_we = 1'b1;
				cmd.cnt_inc  = 1'b1;
				if (stat.cnt_last) begin
					state_d = ST_DONE;
				end
			end
			ST_READ: begin
				cmd.cell_rd = 1'b1;
				state_d     = ST_DONE;
			end
			ST_DONE: begin
				cmd.emit = 1'b1;
				state_d  = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule
